// File: design/xdec_pkg.sv
package xdec_pkg;

    // opcode classes seen by the front end
    typedef enum logic [2:0] {
        CL_NONE,
        CL_JMP,
        CL_RMR,
        CL_IREG,
        CL_IRM,
        CL_MEMACC,
        CL_ACCMEM
    } instr_class_t;

    // operation codes on the result
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_CMP = 3'd3;
    localparam logic [2:0] OP_JCC = 3'd4;

    // form codes on the result
    localparam logic [2:0] FORM_RM_REG   = 3'd0;
    localparam logic [2:0] FORM_IMM_REG  = 3'd1;
    localparam logic [2:0] FORM_IMM_RM   = 3'd2;
    localparam logic [2:0] FORM_MEM_ACC  = 3'd3;
    localparam logic [2:0] FORM_ACC_MEM  = 3'd4;
    localparam logic [2:0] FORM_JUMP     = 3'd5;
    localparam logic [2:0] FORM_UNREC    = 3'd6;

    // opcode patterns
    localparam logic [5:0] PAT_MOV_RM    = 6'b100010;
    localparam logic [6:0] PAT_MOV_IRM   = 7'b1100011;
    localparam logic [3:0] PAT_MOV_IREG  = 4'b1011;
    localparam logic [6:0] PAT_MEM_ACC   = 7'b1010000;
    localparam logic [6:0] PAT_ACC_MEM   = 7'b1010001;
    localparam logic [7:0] MASK_ARITH_RM = 8'b11000100;
    localparam logic [7:0] MASK_ARITH_IA = 8'b11000110;
    localparam logic [7:0] VAL_ARITH_IA  = 8'b00000100;
    localparam logic [2:0] RM_DIRECT     = 3'b110;

    // raw instruction assembled by the front end
    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [2:0]  length;
    } raw_instr_t;

    // decoded record as it leaves the block
    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         form;
        logic               wide;
        logic               reg_is_dest;
        logic               sign_extend;
        logic [1:0]         mode_field;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [7:0]         opcode_byte;
        logic [2:0]         length;
    } dec_rec_t;

    function automatic logic arith_code(input logic [2:0] op);
        return (op == 3'd0) || (op == 3'd5) || (op == 3'd7);
    endfunction

    function automatic logic [2:0] arith_operation(input logic [2:0] op);
        logic [2:0] r;
        case (op)
            3'd0:    r = OP_ADD;
            3'd5:    r = OP_SUB;
            default: r = OP_CMP;
        endcase
        return r;
    endfunction

    function automatic instr_class_t classify(input logic [7:0] b);
        logic ar;
        instr_class_t c;
        ar = arith_code(b[5:3]);
        if ((b inside {[8'h70:8'h7F]}) || (b inside {[8'hE0:8'hE3]}))
            c = CL_JMP;
        else if ((b[7:2] == PAT_MOV_RM) || (ar && ((b & MASK_ARITH_RM) == 8'h00)))
            c = CL_RMR;
        else if ((b[7:4] == PAT_MOV_IREG) || (ar && ((b & MASK_ARITH_IA) == VAL_ARITH_IA)))
            c = CL_IREG;
        else if ((b[7:1] == PAT_MOV_IRM) || (b inside {[8'h80:8'h83]}))
            c = CL_IRM;
        else if (b[7:1] == PAT_MEM_ACC)
            c = CL_MEMACC;
        else if (b[7:1] == PAT_ACC_MEM)
            c = CL_ACCMEM;
        else
            c = CL_NONE;
        return c;
    endfunction

    function automatic logic [1:0] disp_total(input instr_class_t c, input logic [7:0] m);
        logic [1:0] n;
        n = 2'd0;
        case (c)
            CL_JMP:               n = 2'd1;
            CL_MEMACC, CL_ACCMEM: n = 2'd2;
            CL_RMR, CL_IRM: begin
                case (m[7:6])
                    2'd0:    n = (m[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
                    2'd1:    n = 2'd1;
                    2'd2:    n = 2'd2;
                    default: n = 2'd0;
                endcase
            end
            default:              n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] imm_total(input instr_class_t c, input logic [7:0] b);
        logic [1:0] n;
        logic w;
        logic s;
        n = 2'd0;
        case (c)
            CL_IREG: begin
                w = (b[7:4] == PAT_MOV_IREG) ? b[3] : b[0];
                n = w ? 2'd2 : 2'd1;
            end
            CL_IRM: begin
                w = b[0];
                s = (b[7:1] == PAT_MOV_IRM) ? 1'b0 : b[1];
                n = (w && !s) ? 2'd2 : 2'd1;
            end
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// File: design/xdec_front.sv
module xdec_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    input  logic [7:0]          code_byte,
    output logic                push,
    output xdec_pkg::raw_instr_t push_rec
);
    import xdec_pkg::*;

    typedef enum logic [1:0] {PH_OPCODE, PH_MODRM, PH_DISP, PH_IMM} phase_t;

    phase_t       phase_reg, phase_next;
    logic [7:0]   opcode_reg, opcode_next;
    logic [7:0]   modrm_reg, modrm_next;
    logic [2:0]   len_reg, len_next;
    logic [1:0]   dleft_reg, dleft_next;
    logic [1:0]   ileft_reg, ileft_next;
    logic [15:0]  disp_reg, disp_next;
    logic [15:0]  imm_reg, imm_next;
    instr_class_t cls_held;
    instr_class_t cls_new;
    logic [1:0]   dtot;
    logic [1:0]   itot;
    logic         done;
    logic         adv;

    assign cls_held = classify(opcode_reg);
    assign cls_new  = classify(code_byte);
    assign dtot     = disp_total(cls_held, modrm_reg);
    assign itot     = imm_total(cls_held, opcode_reg);

    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        len_next    = len_reg;
        dleft_next  = dleft_reg;
        ileft_next  = ileft_reg;
        disp_next   = disp_reg;
        imm_next    = imm_reg;
        done        = 1'b0;
        adv         = 1'b0;
        if (byte_valid) begin
            case (phase_reg)
                PH_MODRM: begin
                    modrm_next = code_byte;
                    len_next   = len_reg + 3'd1;
                    dleft_next = disp_total(cls_held, code_byte);
                    ileft_next = imm_total(cls_held, opcode_reg);
                    adv        = 1'b1;
                end
                PH_DISP: begin
                    if (dtot == 2'd1)
                        disp_next = {{8{code_byte[7]}}, code_byte};
                    else if (dleft_reg == 2'd2)
                        disp_next = {8'h00, code_byte};
                    else
                        disp_next = {code_byte, disp_reg[7:0]};
                    len_next   = len_reg + 3'd1;
                    dleft_next = dleft_reg - 2'd1;
                    adv        = 1'b1;
                end
                PH_IMM: begin
                    // second byte of a two-byte immediate fills the high half
                    if ((itot == 2'd2) && (ileft_reg == 2'd1))
                        imm_next = {code_byte, imm_reg[7:0]};
                    else
                        imm_next = {8'h00, code_byte};
                    len_next   = len_reg + 3'd1;
                    ileft_next = ileft_reg - 2'd1;
                    adv        = 1'b1;
                end
                default: begin
                    opcode_next = code_byte;
                    modrm_next  = 8'h00;
                    len_next    = 3'd1;
                    disp_next   = 16'h0000;
                    imm_next    = 16'h0000;
                    dleft_next  = 2'd0;
                    ileft_next  = 2'd0;
                    case (cls_new)
                        CL_NONE: begin
                            done = 1'b1;
                        end
                        CL_RMR, CL_IRM: begin
                            phase_next = PH_MODRM;
                        end
                        default: begin
                            dleft_next = disp_total(cls_new, 8'h00);
                            ileft_next = imm_total(cls_new, code_byte);
                            adv        = 1'b1;
                        end
                    endcase
                end
            endcase
            if (adv) begin
                if (dleft_next != 2'd0)
                    phase_next = PH_DISP;
                else if (ileft_next != 2'd0)
                    phase_next = PH_IMM;
                else
                    done = 1'b1;
            end
            if (done)
                phase_next = PH_OPCODE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_OPCODE;
            opcode_reg <= 8'h00;
            modrm_reg  <= 8'h00;
            len_reg    <= 3'd0;
            dleft_reg  <= 2'd0;
            ileft_reg  <= 2'd0;
            disp_reg   <= 16'h0000;
            imm_reg    <= 16'h0000;
        end else begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            len_reg    <= len_next;
            dleft_reg  <= dleft_next;
            ileft_reg  <= ileft_next;
            disp_reg   <= disp_next;
            imm_reg    <= imm_next;
        end
    end

    assign push            = done;
    assign push_rec.opcode = opcode_next;
    assign push_rec.modrm  = modrm_next;
    assign push_rec.disp   = disp_next;
    assign push_rec.imm    = imm_next;
    assign push_rec.length = len_next;

endmodule

// File: design/xdec_fifo.sv
module xdec_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  xdec_pkg::raw_instr_t push_rec,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output xdec_pkg::raw_instr_t head_rec
);
    import xdec_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    raw_instr_t    store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_rec  = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// File: design/xdec_back.sv
module xdec_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  xdec_pkg::raw_instr_t head_rec,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output xdec_pkg::dec_rec_t   out_rec
);
    import xdec_pkg::*;

    instr_class_t cls;
    dec_rec_t     dec;
    dec_rec_t     rec_reg;
    logic         valid_reg, valid_next;
    logic [7:0]   b;
    logic [7:0]   m;

    assign b   = head_rec.opcode;
    assign m   = head_rec.modrm;
    assign cls = classify(b);

    always_comb begin
        dec              = '0;
        dec.opcode_byte  = b;
        dec.length       = head_rec.length;
        dec.displacement = head_rec.disp;
        dec.immediate    = head_rec.imm;
        if ((cls == CL_RMR) || (cls == CL_IRM)) begin
            dec.mode_field = m[7:6];
            dec.reg_field  = m[5:3];
            dec.rm_field   = m[2:0];
            dec.wide       = b[0];
        end
        case (cls)
            CL_JMP: begin
                dec.operation = OP_JCC;
                dec.form      = FORM_JUMP;
            end
            CL_RMR: begin
                dec.operation   = (b[7:2] == PAT_MOV_RM) ? OP_MOV : arith_operation(b[5:3]);
                dec.form        = FORM_RM_REG;
                dec.reg_is_dest = b[1];
            end
            CL_IREG: begin
                dec.form = FORM_IMM_REG;
                if (b[7:4] == PAT_MOV_IREG) begin
                    dec.operation = OP_MOV;
                    dec.wide      = b[3];
                    dec.reg_field = b[2:0];
                end else begin
                    dec.operation = arith_operation(b[5:3]);
                    dec.wide      = b[0];
                end
            end
            CL_IRM: begin
                if (b[7:1] == PAT_MOV_IRM) begin
                    dec.operation = OP_MOV;
                    dec.form      = FORM_IMM_RM;
                end else begin
                    dec.sign_extend = b[1];
                    // group opcodes with a reg field other than add, sub or cmp
                    if (arith_code(m[5:3])) begin
                        dec.operation = arith_operation(m[5:3]);
                        dec.form      = FORM_IMM_RM;
                    end else begin
                        dec.operation = OP_MOV;
                        dec.form      = FORM_UNREC;
                    end
                end
            end
            CL_MEMACC: begin
                dec.operation = OP_MOV;
                dec.form      = FORM_MEM_ACC;
                dec.wide      = b[0];
            end
            CL_ACCMEM: begin
                dec.operation = OP_MOV;
                dec.form      = FORM_ACC_MEM;
                dec.wide      = b[0];
            end
            default: begin
                dec.operation    = OP_MOV;
                dec.form         = FORM_UNREC;
                dec.displacement = '0;
                dec.immediate    = '0;
                dec.length       = 3'd1;
            end
        endcase
    end

    assign pop = head_valid && (!valid_reg || out_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (pop)
            rec_reg <= dec;
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

// File: design/x86_16bit_instruction_field_decoder_core.sv
// a record enters the queue on its last byte, then the output register once that is free
// throughput: one code byte per cycle while the queue is not full, one record per cycle
// set by the front tracker; the back end drains at that rate while m_tready is high
// reset: aresetn low at a rising edge clears the byte tracker, the queue and m_tvalid
// the first byte after reset is taken as an opcode
module x86_16bit_instruction_field_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] operation, [5:3] form, [6] wide, [7] reg_is_dest, [8] sign_extend,
    // [10:9] mode_field, [13:11] reg_field, [16:14] rm_field, [32:17] displacement,
    // [48:33] immediate, [56:49] opcode_byte, [59:57] length, [63:60] zero
    output logic [63:0] m_tdata
);
    import xdec_pkg::*;

    // front end: byte tracker that assembles one instruction
    logic       byte_beat;
    logic       push;
    raw_instr_t push_rec;

    // queue between front and back
    logic       q_full;
    logic       q_not_empty;
    logic       pop;
    raw_instr_t head_rec;

    // back end: field decode and output register
    dec_rec_t   out_rec;

    // a byte beat is taken whenever the queue has room for a finished record
    assign s_tready  = !q_full;
    assign byte_beat = s_tvalid && s_tready;

    xdec_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_beat),
        .code_byte  (s_tdata),
        .push       (push),
        .push_rec   (push_rec)
    );

    xdec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_rec  (head_rec)
    );

    xdec_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_not_empty),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (out_rec)
    );

    // pack the record, first field in the low bits
    assign m_tdata = {4'b0000,
                      out_rec.length,
                      out_rec.opcode_byte,
                      out_rec.immediate,
                      out_rec.displacement,
                      out_rec.rm_field,
                      out_rec.reg_field,
                      out_rec.mode_field,
                      out_rec.sign_extend,
                      out_rec.reg_is_dest,
                      out_rec.wide,
                      out_rec.form,
                      out_rec.operation};

`ifndef SYNTH
    // the queue only fills up behind a record held at the output
    a_backpressure_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled without a held output record");

    // a jump record is always the opcode plus one offset byte
    a_jump_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_rec.form == FORM_JUMP)) |->
            ((out_rec.operation == OP_JCC) && (out_rec.length == 3'd2)))
        else $error("jump record with wrong operation or length");

    // recorded lengths stay within one to six bytes
    a_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_rec.length != 3'd0) && (out_rec.length != 3'd7)))
        else $error("record length out of range");
`endif

endmodule
